>>> sv/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer assertion macros
// Concurrent check wrappers, clocked on clk and idle during arst_n.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every edge
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// antecedent implies consequent in the same cycle
`define TCW_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_IMPLY(lbl, ante, cons, msg)
`endif
`endif

>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and transfer types of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int BUFFER_WORDS = 16384;
	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int SCREEN_WORDS = COLUMNS * ROWS;
	localparam int TAB_STOP     = 4;
	localparam int LAST_TAB_COL = COLUMNS - 1;
	// display start at or past this point relocates the screen before a scroll
	localparam int RELOC_AT     = BUFFER_WORDS - SCREEN_WORDS - COLUMNS;

	localparam int AW         = $clog2(BUFFER_WORDS);
	localparam int TAB_W      = $clog2(TAB_STOP);
	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int OFS_W      = 14;
	localparam int DATA_W     = 16;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int COLOUR_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int Q_DEPTH = 2;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_CELL  = 1'd1;

	localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RST = 8'd7;
	localparam logic [DATA_W-1:0]   BLANK_CELL_RST  = 16'h0720;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CHAR_W-1:0] char_code;
		logic [OFS_W-1:0]  cell_index;
	} tcw_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [OFS_W-1:0]  cursor_offset;
		logic [OFS_W-1:0]  display_start;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
	} tcw_out_t;

	typedef enum logic [3:0] {
		K_NUL,
		K_BS,
		K_HT,
		K_LF,
		K_CR,
		K_PRINT,
		K_CLEAR,
		K_READ,
		K_NONE
	} tcw_kind_t;

	typedef struct packed {
		tcw_kind_t         kind;
		logic [CHAR_W-1:0] char_code;
		logic [OFS_W-1:0]  cell_index;
	} tcw_op_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic    valid;
		tcw_op_t item;
	} tcw_q_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] text_colour;
		logic [DATA_W-1:0]   blank_cell;
	} tcw_cfg_t;

endpackage

`default_nettype wire

>>> sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> sv/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts commands, decodes them into operation kinds, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tcw_pkg::tcw_in_t in_data,
	output tcw_pkg::tcw_q_t  q_head,
	input  logic             q_pop
);

	import tcw_pkg::*;
	`include "text_console_writer_assert.svh"

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

	function automatic tcw_op_t classify(input tcw_in_t it);
		tcw_op_t op;
		op.char_code  = it.char_code;
		op.cell_index = it.cell_index;
		case (it.cmd)
			CMD_PUT: begin
				case (it.char_code)
					CH_NUL:  op.kind = K_NUL;
					CH_BS:   op.kind = K_BS;
					CH_HT:   op.kind = K_HT;
					CH_LF:   op.kind = K_LF;
					CH_CR:   op.kind = K_CR;
					default: op.kind = K_PRINT;
				endcase
			end
			CMD_CLEAR: op.kind = K_CLEAR;
			CMD_READ:  op.kind = K_READ;
			default:   op.kind = K_NONE;
		endcase
		return op;
	endfunction

	tcw_op_t          fifo_q [Q_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  count_q;
	logic             push;

	assign in_stall     = (count_q == QC_W'(Q_DEPTH));
	assign push         = in_valid && !in_stall;
	assign q_head.valid = (count_q != '0);
	assign q_head.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= classify(in_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + QC_W'(1);
				2'b01:   count_q <= count_q - QC_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`TCW_IMPLY(a_no_pop_empty, q_pop, count_q != '0, "pop from empty command queue")
	`TCW_ASSERT(a_queue_bound, count_q <= QC_W'(Q_DEPTH), "command queue overfilled")

endmodule

`default_nettype wire

>>> sv/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued console operations on the cell buffer and cursor state.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_pkg::tcw_cfg_t cfg,
	input  tcw_pkg::tcw_q_t   q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output tcw_pkg::tcw_out_t out_data
);

	import tcw_pkg::*;
	`include "text_console_writer_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TAB,
		S_RD,
		S_COPY,
		S_BLANK,
		S_CLEAR,
		S_DONE
	} state_t;

	state_t            state_q;
	tcw_kind_t         op_q;
	logic [CHAR_W-1:0] char_q;
	logic [OFS_W-1:0]  idx_q;
	logic              print_pend_q;
	logic [AW-1:0]     cursor_q;
	logic [AW-1:0]     start_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [AW-1:0]     cnt_q;
	logic [DATA_W-1:0] rd_q;
	logic              out_valid_q;
	tcw_out_t          out_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic              slot_free;
	logic [AW-1:0]     cr_cursor;
	logic              last_row;
	logic              reloc;
	logic [COL_W-1:0]  col_inc;

	assign slot_free = !out_valid_q || !out_stall;
	assign q_pop     = q_head.valid && ((state_q == S_IDLE) || ((state_q == S_DONE) && slot_free));
	assign cr_cursor = cursor_q - AW'(col_q);
	assign last_row  = (row_q == ROW_W'(ROWS - 1));
	assign reloc     = (start_q >= AW'(RELOC_AT));
	assign col_inc   = col_q + COL_W'(1);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cursor_q;
		ram_wdata = cfg.blank_cell;
		ram_raddr = AW'(idx_q);
		case (state_q)
			S_EXEC: begin
				case (op_q)
					K_BS: begin
						ram_we    = (col_q != '0);
						ram_waddr = cursor_q - AW'(1);
					end
					K_PRINT: begin
						ram_we    = (col_q < COL_W'(COLUMNS));
						ram_wdata = {cfg.text_colour, char_q};
					end
					default: ;
				endcase
			end
			S_TAB: ram_we = 1'b1;
			S_COPY: begin
				// read one ahead, write the word fetched last cycle
				ram_raddr = start_q + cnt_q;
				ram_we    = (cnt_q != '0);
				ram_waddr = cnt_q - AW'(1);
				ram_wdata = ram_rdata;
			end
			S_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = start_q + AW'(SCREEN_WORDS) + cnt_q;
			end
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
			end
			default: ;
		endcase
	end

	tcw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(BUFFER_WORDS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= K_NUL;
			char_q       <= '0;
			idx_q        <= '0;
			print_pend_q <= 1'b0;
			cursor_q     <= '0;
			start_q      <= '0;
			col_q        <= '0;
			row_q        <= '0;
			cnt_q        <= '0;
			rd_q         <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			// done state reloads the slot itself when it is free
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				op_q         <= q_head.item.kind;
				char_q       <= q_head.item.char_code;
				idx_q        <= q_head.item.cell_index;
				rd_q         <= '0;
				print_pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						K_BS: begin
							if (col_q != '0) begin
								col_q    <= col_q - COL_W'(1);
								cursor_q <= cursor_q - AW'(1);
							end
							state_q <= S_DONE;
						end
						K_HT: begin
							state_q <= (col_q >= COL_W'(LAST_TAB_COL)) ? S_DONE : S_TAB;
						end
						K_CR: begin
							cursor_q <= cr_cursor;
							col_q    <= '0;
							state_q  <= S_DONE;
						end
						K_LF: begin
							col_q <= '0;
							cnt_q <= '0;
							if (!last_row) begin
								row_q    <= row_q + ROW_W'(1);
								cursor_q <= cr_cursor + AW'(COLUMNS);
								if (print_pend_q) begin
									op_q         <= K_PRINT;
									print_pend_q <= 1'b0;
									state_q      <= S_EXEC;
								end else begin
									state_q <= S_DONE;
								end
							end else begin
								cursor_q <= cr_cursor;
								state_q  <= reloc ? S_COPY : S_BLANK;
							end
						end
						K_PRINT: begin
							if (col_q >= COL_W'(COLUMNS)) begin
								// wrap: back to column 0, line feed, then print
								col_q        <= '0;
								cursor_q     <= cursor_q - AW'(COLUMNS);
								op_q         <= K_LF;
								print_pend_q <= 1'b1;
							end else begin
								cursor_q <= cursor_q + AW'(1);
								col_q    <= col_inc;
								state_q  <= S_DONE;
							end
						end
						K_CLEAR: begin
							cursor_q <= '0;
							start_q  <= '0;
							col_q    <= '0;
							row_q    <= '0;
							cnt_q    <= '0;
							state_q  <= S_CLEAR;
						end
						K_READ: state_q <= S_RD;
						default: state_q <= S_DONE;
					endcase
				end
				S_TAB: begin
					cursor_q <= cursor_q + AW'(1);
					col_q    <= col_inc;
					if (col_inc[TAB_W-1:0] == '0) begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					rd_q    <= ram_rdata;
					state_q <= S_DONE;
				end
				S_COPY: begin
					if (cnt_q == AW'(SCREEN_WORDS)) begin
						cursor_q <= cursor_q - start_q;
						start_q  <= '0;
						cnt_q    <= '0;
						state_q  <= S_BLANK;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_BLANK: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(COLUMNS - 1)) begin
						start_q  <= start_q + AW'(COLUMNS);
						cursor_q <= cursor_q + AW'(COLUMNS);
						if (print_pend_q) begin
							op_q         <= K_PRINT;
							print_pend_q <= 1'b0;
							state_q      <= S_EXEC;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(BUFFER_WORDS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q         <= 1'b1;
						out_q.read_data     <= rd_q;
						out_q.cursor_offset <= OFS_W'(cursor_q);
						out_q.display_start <= OFS_W'(start_q);
						out_q.cursor_col    <= col_q;
						out_q.cursor_row    <= row_q;
						state_q             <= q_pop ? S_EXEC : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TCW_ASSERT(a_col_range, col_q <= COL_W'(COLUMNS), "column past wrap point")
	`TCW_ASSERT(a_row_range, row_q <= ROW_W'(ROWS - 1), "row below screen")
	`TCW_IMPLY(a_copy_needed, state_q == S_COPY, start_q >= AW'(RELOC_AT), "relocation not due")
	`TCW_IMPLY(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result not from done")

endmodule

`default_nettype wire

>>> sv/text_console_writer.sv
// Each queued operation runs to completion before the next is popped. On the last
// row an LF or wrap blanks a new row below the screen, after first copying the
// screen back to offset 0 when relocation is due. Clear walks the whole buffer.
// Operations share the single RAM write port; a 2-entry queue decouples input.
// Reset clears cursor, display start, column, row and queue; cell RAM is not cleared.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: interprets put/clear/read commands against a cell buffer
// and reports CRT cursor and display start offsets for every command.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	// command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tcw_pkg::tcw_in_t                  in_data,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output tcw_pkg::tcw_out_t                 out_data,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	import tcw_pkg::*;

	// Configuration registers. Software is to write them only while idle; the block
	// does not enforce it. The back end reads them directly without any shadowing.
	tcw_cfg_t cfg_q;

	// Front to back: head of the decoded command queue and its pop strobe.
	tcw_q_t   q_head;
	logic     q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_colour <= TEXT_COLOUR_RST;
			cfg_q.blank_cell  <= BLANK_CELL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_COLOUR: cfg_q.text_colour <= cfg_wdata[COLOUR_W-1:0];
				REG_BLANK_CELL:  cfg_q.blank_cell  <= cfg_wdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: takes a transfer whenever the queue has room, decodes the
	// command and control characters into an operation kind.
	tcw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	// Back: sequencer that owns cursor state and the cell RAM, and the
	// output register that holds a finished result until it is taken.
	tcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

>>> verif/text_console_writer_checker.sv
// ----------------------------------------------------------------------------
// text_console_writer checker
// Watches the command, result and register ports, keeps a shadow console
// and compares every result transfer against the oldest predicted report.
// ----------------------------------------------------------------------------

package console_codes_pkg;

	localparam logic [tcw_pkg::CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [tcw_pkg::CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [tcw_pkg::CHAR_W-1:0] CH_HT  = 8'h09;
	localparam logic [tcw_pkg::CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [tcw_pkg::CHAR_W-1:0] CH_CR  = 8'h0D;

	// command code the block treats as a no-op
	localparam logic [tcw_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

endpackage

module text_console_writer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  tcw_pkg::tcw_in_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  tcw_pkg::tcw_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             pending,
	output logic [tcw_pkg::COL_W-1:0]      column_now
);

	import tcw_pkg::*;
	import console_codes_pkg::*;

	logic [DATA_W-1:0]   cells [BUFFER_WORDS];
	int unsigned         cursor_pos;
	int unsigned         view_base;
	int unsigned         col;
	int unsigned         row;
	logic [COLOUR_W-1:0] colour;
	logic [DATA_W-1:0]   blank;
	tcw_out_t            reports_due [$];

	assign column_now = col[COL_W-1:0];

	function automatic void store(int unsigned addr, logic [DATA_W-1:0] word);
		cells[AW'(addr % BUFFER_WORDS)] = word;
	endfunction

	function automatic void scroll_screen();
		// near the top of the buffer the visible screen moves back to offset 0
		if (view_base + SCREEN_WORDS + COLUMNS >= BUFFER_WORDS) begin
			for (int i = 0; i < SCREEN_WORDS; i++)
				store(i, cells[AW'((view_base + i) % BUFFER_WORDS)]);
			cursor_pos -= view_base;
			view_base = 0;
		end
		for (int i = 0; i < COLUMNS; i++)
			store(view_base + SCREEN_WORDS + i, blank);
		view_base += COLUMNS;
		cursor_pos += COLUMNS;
	endfunction

	function automatic void new_line();
		cursor_pos -= col;
		col = 0;
		if (row + 1 < ROWS) begin
			row++;
			cursor_pos += COLUMNS;
		end else begin
			scroll_screen();
		end
	endfunction

	function automatic void put_char(logic [CHAR_W-1:0] ch);
		int unsigned pad;
		case (ch)
			CH_NUL: begin
			end
			CH_BS: begin
				if (col > 0) begin
					col--;
					cursor_pos--;
					store(cursor_pos, blank);
				end
			end
			CH_HT: begin
				// no tab at or past the last column
				if (col < LAST_TAB_COL) begin
					pad = TAB_STOP - (col % TAB_STOP);
					for (int i = 0; i < pad; i++)
						store(cursor_pos + i, blank);
					cursor_pos += pad;
					col += pad;
				end
			end
			CH_LF: new_line();
			CH_CR: begin
				cursor_pos -= col;
				col = 0;
			end
			default: begin
				// pending wrap is resolved before the character lands
				if (col >= COLUMNS) begin
					col -= COLUMNS;
					cursor_pos -= COLUMNS;
					new_line();
				end
				store(cursor_pos, {colour, ch});
				cursor_pos++;
				col++;
			end
		endcase
	endfunction

	function automatic tcw_out_t console_report(tcw_in_t item);
		tcw_out_t rpt;
		rpt = '0;
		case (item.cmd)
			CMD_PUT: put_char(item.char_code);
			CMD_CLEAR: begin
				view_base = 0;
				cursor_pos = 0;
				col = 0;
				row = 0;
				for (int i = 0; i < BUFFER_WORDS; i++)
					cells[AW'(i)] = blank;
			end
			CMD_READ: rpt.read_data = cells[item.cell_index];
			default: begin
			end
		endcase
		rpt.cursor_offset = cursor_pos[OFS_W-1:0];
		rpt.display_start = view_base[OFS_W-1:0];
		rpt.cursor_col    = col[COL_W-1:0];
		rpt.cursor_row    = row[ROW_W-1:0];
		return rpt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tcw_out_t want;
		if (!arst_n) begin
			cursor_pos = 0;
			view_base  = 0;
			col        = 0;
			row        = 0;
			colour     = TEXT_COLOUR_RST;
			blank      = BLANK_CELL_RST;
			reports_due.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			// result side first: a command never answers in its own cycle
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result transfer with none outstanding: data=%h",
							$time, out_data);
				end else begin
					want = reports_due.pop_front();
					if (out_data.read_data !== want.read_data ||
						out_data.cursor_offset !== want.cursor_offset ||
						out_data.display_start !== want.display_start ||
						out_data.cursor_col !== want.cursor_col ||
						out_data.cursor_row !== want.cursor_row) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected data=%h cursor=%0d start=%0d col=%0d row=%0d",
								want.read_data, want.cursor_offset,
								want.display_start, want.cursor_col, want.cursor_row);
							$display("  actual   data=%h cursor=%0d start=%0d col=%0d row=%0d",
								out_data.read_data, out_data.cursor_offset,
								out_data.display_start, out_data.cursor_col,
								out_data.cursor_row);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				reports_due.push_back(console_report(in_data));
			if (cfg_we) begin
				case (cfg_index)
					REG_TEXT_COLOUR: colour = cfg_wdata[COLOUR_W-1:0];
					REG_BLANK_CELL:  blank  = cfg_wdata[DATA_W-1:0];
					default: begin
					end
				endcase
			end
			pending = reports_due.size();
		end
	end

endmodule

>>> verif/text_console_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer testbench
// Drives put, clear and read commands with random idle gaps and result
// stalls, over several colour and blank settings. A short directed opening
// hits the control codes and field extremes; random phases then cover long
// wrapping lines with edge-of-row tabs, a scroll run deep enough to force
// the screen relocation, and mixed traffic with clears and reads. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module text_console_writer_tb;
	import tcw_pkg::*;
	import console_codes_pkg::*;

	// watchdog bound on the whole run; clears dominate its length
	localparam int CYCLE_LIMIT = 2_000_000;
	// idle cycles after the last result before a register write
	localparam int CFG_SETTLE  = 16;
	// quiet window at the end to catch stray result transfers
	localparam int END_SETTLE  = 64;

	typedef enum int {
		MIX_GENERAL,
		MIX_LONG_LINES,
		MIX_SCROLL
	} mix_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	tcw_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	tcw_out_t              out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int                    fail_count;
	int                    pending;
	logic [COL_W-1:0]      column_now;
	int                    burst_left  = 0;
	int                    cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_writer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	text_console_writer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.column_now (column_now)
	);

	// Sender idle gaps: mostly none or short, a few long, and now and then a
	// burst of back-to-back transfers.
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic tcw_in_t mk(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
		logic [OFS_W-1:0] idx);
		tcw_in_t item;
		item.cmd        = cmd;
		item.char_code  = ch;
		item.cell_index = idx;
		return item;
	endfunction

	// Don't-care fields stay random so every payload bit toggles.
	function automatic tcw_in_t random_item(mix_t mix, int step);
		tcw_in_t item;
		int      r;
		item.cmd        = CMD_PUT;
		item.char_code  = CHAR_W'($urandom_range(0, 255));
		item.cell_index = OFS_W'($urandom_range(0, BUFFER_WORDS - 1));
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GENERAL: begin
				if (r < 45) begin
				end else if (r < 55) item.char_code = CH_HT;
				else if (r < 62) item.char_code = CH_BS;
				else if (r < 70) item.char_code = CH_LF;
				else if (r < 75) item.char_code = CH_CR;
				else if (r < 77) item.char_code = CH_NUL;
				else if (r < 93) begin
					item.cmd = CMD_READ;
					// half the reads land on the first screen and the row below
					if ($urandom_range(0, 1))
						item.cell_index = OFS_W'($urandom_range(0, SCREEN_WORDS + COLUMNS - 1));
				end else if (r < 96) item.cmd = CMD_NONE;
				else item.cmd = CMD_CLEAR;
			end
			MIX_LONG_LINES: begin
				// steer toward tabs at the last column and at wrap pending
				if (column_now >= LAST_TAB_COL && $urandom_range(0, 1))
					item.char_code = CH_HT;
				else if (column_now == COLUMNS && $urandom_range(0, 3) == 0)
					item.char_code = CH_BS;
				else if (r < 60) begin
				end else if (r < 90) item.char_code = CH_HT;
				else if (r < 93) item.char_code = CH_BS;
				else item.cmd = CMD_READ;
			end
			default: begin
				// nine line feeds in ten: enough to scroll past the relocation point
				if (step % 10 != 9) item.char_code = CH_LF;
				else if (r < 40) begin
					item.cmd        = CMD_READ;
					item.cell_index = OFS_W'($urandom_range(0, SCREEN_WORDS + COLUMNS - 1));
				end else if (r < 60) item.cmd = CMD_READ;
				else if (r >= 80) item.char_code = CH_HT;
			end
		endcase
		return item;
	endfunction

	// One command transfer, then an optional idle gap. Called at a falling
	// edge; returns at a falling edge.
	task automatic send(input tcw_in_t item);
		int gap;
		in_data  = item;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		gap = next_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Sender holds off until every outstanding result has come back.
	task automatic drain(input int settle);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Both registers, back to back; upper data bits of the colour write are
	// junk the block must ignore.
	task automatic set_regs(input logic [COLOUR_W-1:0] colour,
		input logic [DATA_W-1:0] blank);
		cfg_we    = 1'b1;
		cfg_index = REG_TEXT_COLOUR;
		cfg_wdata = {8'($urandom), colour};
		@(negedge clk);
		cfg_index = REG_BLANK_CELL;
		cfg_wdata = blank;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic run_phase(input logic [COLOUR_W-1:0] colour,
		input logic [DATA_W-1:0] blank, input int count, input mix_t mix);
		drain(CFG_SETTLE);
		set_regs(colour, blank);
		for (int i = 0; i < count; i++)
			send(random_item(mix, i));
	endtask

	// Result side stalls: short holds most of the time, an occasional long
	// one, and quiet stretches with no stall at all.
	initial begin
		int hold;
		int quiet;
		int r;
		hold  = 0;
		quiet = 0;
		forever begin
			@(negedge clk);
			if (quiet > 0) begin
				quiet--;
				out_stall = 1'b0;
			end else if (hold > 0) begin
				hold--;
				out_stall = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					quiet     = $urandom_range(50, 200);
					out_stall = 1'b0;
				end else if (r < 60) begin
					out_stall = 1'b0;
				end else if (r < 95) begin
					hold      = $urandom_range(0, 3);
					out_stall = 1'b1;
				end else begin
					hold      = $urandom_range(15, 60);
					out_stall = 1'b1;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening at reset register values. The first command is a
		// clear, so no read ever touches a cell that was never written.
		send(mk(CMD_CLEAR, 8'h5A, 14'h3FFF));
		send(mk(CMD_READ, CH_NUL, '0));
		send(mk(CMD_READ, 8'hFF, 14'h3FFF));
		send(mk(CMD_PUT, CH_NUL, '0));
		send(mk(CMD_PUT, CH_BS, '0));            // column 0: nothing to erase
		send(mk(CMD_PUT, 8'hFF, '0));
		send(mk(CMD_PUT, 8'h01, '0));
		send(mk(CMD_PUT, 8'h7F, '0));
		send(mk(CMD_PUT, CH_BS, '0));            // erases the cell just written
		send(mk(CMD_READ, 8'h00, 14'd2));
		send(mk(CMD_READ, 8'h00, 14'd0));
		send(mk(CMD_PUT, CH_HT, '0));
		send(mk(CMD_PUT, CH_HT, '0));
		send(mk(CMD_PUT, 8'h0C, '0));            // other control bytes print
		send(mk(CMD_PUT, CH_HT, '0));
		send(mk(CMD_PUT, CH_CR, '0));
		send(mk(CMD_PUT, CH_LF, '0));
		send(mk(CMD_PUT, 8'h0B, '0));
		send(mk(CMD_NONE, 8'hAA, 14'h2AAA));     // unused command code
		send(mk(CMD_READ, 8'h55, 14'h1555));
		send(mk(CMD_READ, 8'h00, OFS_W'(COLUMNS)));

		// Random phases, each behind a full drain and a register update.
		run_phase(8'h1F, 16'h0000, 50, MIX_GENERAL);
		run_phase(8'hFF, 16'hFFFF, 100, MIX_LONG_LINES);
		run_phase(8'h00, BLANK_CELL_RST, 240, MIX_SCROLL);
		run_phase(COLOUR_W'($urandom_range(1, 254)), DATA_W'($urandom_range(1, 65534)),
			50, MIX_GENERAL);

		drain(END_SETTLE);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> text_console_writer.f
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_writer.sv
verif/text_console_writer_checker.sv
verif/text_console_writer_tb.sv
